>>> hw/rtl/hough_circle_best_match_assert.svh
// Assertion macros for the circle Hough voting block.
// Needs clk and rst_n in the scope of use.
`ifndef HOUGH_CIRCLE_BEST_MATCH_ASSERT_SVH
`define HOUGH_CIRCLE_BEST_MATCH_ASSERT_SVH

// Same-cycle implication.
`define HCBM_AST_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcbm: implication check failed");

// Next-cycle implication.
`define HCBM_AST_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcbm: next-cycle check failed");

`endif

>>> hw/rtl/hcbm_pkg.sv
// Package for the circle Hough voting block: beat types, multiplier request type and fixed constants.
// No dependencies.
`timescale 1ns / 1ps

package hcbm_pkg;

    localparam int COORD_BITS = 10;
    localparam int MUL_W      = 20;
    localparam int RS_BITS    = 10;
    localparam int D_BITS     = 13;
    localparam int CNT_BITS   = 16;
    localparam int E_SLOPE    = 581;
    localparam int E_OFFSET   = 530;
    localparam int RECIP_K    = 671089;
    localparam int RECIP_SH   = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ACCUM_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCUM_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_TABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_RADII    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VOTE_FRAC    = 3'd5;

    localparam logic CMD_VOTE   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef struct packed {
        logic                  command;
        logic [COORD_BITS-1:0] edge_x;
        logic [COORD_BITS-1:0] edge_y;
    } in_beat_t;

    typedef struct packed {
        logic        found;
        logic [6:0]  center_x;
        logic [6:0]  center_y;
        logic [1:0]  radius_index;
        logic [15:0] votes;
    } out_beat_t;

    typedef struct packed {
        logic [MUL_W-1:0] op_a;
        logic [MUL_W-1:0] op_b;
    } mul_req_t;

endpackage

>>> hw/rtl/hcbm_mul.sv
// Shared registered multiplier for scaling and threshold arithmetic.
// Depends on hcbm_pkg.
`timescale 1ns / 1ps

module hcbm_mul (
    input  logic                            clk,
    input  hcbm_pkg::mul_req_t              req,
    output logic [2*hcbm_pkg::MUL_W-1:0]    prod
);

    logic [2*hcbm_pkg::MUL_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= req.op_a * req.op_b;
    end

    assign prod = prod_reg;

endmodule

>>> hw/rtl/hough_circle_best_match.sv
// Top level of the circle Hough voting block: sequencer, accumulator memory, scan.
// Depends on hcbm_pkg, hcbm_mul and hough_circle_best_match_assert.svh.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | in_data (command, edge_x, edge_y)
//  out     | output    | out_valid/out_ready  | out_data (found, center, radius, votes)
//  cfg     | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Vote: setup states VSX, VSY and VCY, then per radius VRM and VRI, then per midpoint
// step one read state per octant point and one write state per in-area point.
// Finish: one pass over all 2^(YB+XB+RB) cells (read, compare, clear), then DRAIN, T0 to T4 and OUT.
// After reset the same pass clears all 2^(YB+XB+RB) cells, 65536 by default.
// in_ready is low while an item is in work; a waiting result blocks only the next finish.
`timescale 1ns / 1ps
`include "hough_circle_best_match_assert.svh"

module hough_circle_best_match #(
    parameter int ACC_WIDTH  = 128,
    parameter int ACC_HEIGHT = 128,
    parameter int NUM_RADII  = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  hcbm_pkg::in_beat_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output hcbm_pkg::out_beat_t                  out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hcbm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hcbm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int COORD_BITS = hcbm_pkg::COORD_BITS;
    localparam int XB    = $clog2(ACC_WIDTH);
    localparam int YB    = $clog2(ACC_HEIGHT);
    localparam int RB    = (NUM_RADII > 1) ? $clog2(NUM_RADII) : 1;
    localparam int AB    = XB + YB + RB;
    localparam int CXW   = COORD_BITS + 1;
    localparam int CW    = ((CXW > hcbm_pkg::RS_BITS) ? CXW : hcbm_pkg::RS_BITS) + 2;
    localparam int NLIM  = (NUM_RADII < 4) ? NUM_RADII : 4;
    localparam int MW    = hcbm_pkg::MUL_W;
    localparam int RSB   = hcbm_pkg::RS_BITS;
    localparam int DB    = hcbm_pkg::D_BITS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_DRAIN = 4'd2;
    localparam logic [3:0] S_VSX   = 4'd3;
    localparam logic [3:0] S_VSY   = 4'd4;
    localparam logic [3:0] S_VCY   = 4'd5;
    localparam logic [3:0] S_VRM   = 4'd6;
    localparam logic [3:0] S_VRI   = 4'd7;
    localparam logic [3:0] S_RD    = 4'd8;
    localparam logic [3:0] S_WR    = 4'd9;
    localparam logic [3:0] S_T0    = 4'd10;
    localparam logic [3:0] S_T1    = 4'd11;
    localparam logic [3:0] S_T2    = 4'd12;
    localparam logic [3:0] S_T3    = 4'd13;
    localparam logic [3:0] S_T4    = 4'd14;
    localparam logic [3:0] S_OUT   = 4'd15;

    logic [3:0]            state_reg, state_next;
    logic [7:0]            acc_w_reg, acc_h_reg;
    logic [8:0]            inv_reg, frac_reg;
    logic [31:0]           rtab_reg;
    logic [2:0]            nrad_reg;

    logic [COORD_BITS-1:0] ex_reg, ey_reg;
    logic [CXW-1:0]        cx_reg, cy_reg;
    logic [RB-1:0]         ridx_reg;
    logic [RSB-1:0]        a_reg, b_reg;
    logic signed [DB-1:0]  d_reg;
    logic [2:0]            k_reg;
    logic [AB-1:0]         waddr_reg;
    logic [AB-1:0]         cnt_reg;
    logic                  cmp_reg, pv_reg;
    logic [AB-1:0]         paddr_reg;
    logic [15:0]           best_reg;
    logic [XB-1:0]         bx_reg;
    logic [YB-1:0]         by_reg;
    logic [RB-1:0]         bi_reg;
    logic [12:0]           thr_reg;
    logic                  out_valid_reg;
    hcbm_pkg::out_beat_t   out_reg;

    logic [15:0]           mem [2**AB];
    logic [15:0]           rdata_reg;
    logic                  mem_we, mem_re;
    logic [AB-1:0]         mem_waddr, mem_raddr;
    logic [15:0]           mem_wdata;

    hcbm_pkg::mul_req_t    mreq;
    logic [2*MW-1:0]       prod;

    logic [10:0]           w_lim, h_lim;
    logic [2:0]            n_used;
    logic signed [CW-1:0]  sa, sb, scx, scy, dx, dy, bxs, bys;
    logic                  bump_in;
    logic [AB-1:0]         bump_addr;
    logic                  step_last, rad_last;
    logic [RB-1:0]         p_r;
    logic [XB-1:0]         p_x;
    logic [YB-1:0]         p_y;
    logic                  p_in;

    hcbm_mul u_mul (
        .clk  (clk),
        .req  (mreq),
        .prod (prod)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign w_lim  = (11'(acc_w_reg) > 11'(ACC_WIDTH))  ? 11'(ACC_WIDTH)  : 11'(acc_w_reg);
    assign h_lim  = (11'(acc_h_reg) > 11'(ACC_HEIGHT)) ? 11'(ACC_HEIGHT) : 11'(acc_h_reg);
    assign n_used = (nrad_reg > 3'(NLIM)) ? 3'(NLIM) : nrad_reg;

    assign sa  = $signed(CW'(a_reg));
    assign sb  = $signed(CW'(b_reg));
    assign scx = $signed(CW'(cx_reg));
    assign scy = $signed(CW'(cy_reg));

    always_comb
    begin
        unique case (k_reg)
            3'd0: begin dx = sa;  dy = sb;  end
            3'd1: begin dx = -sa; dy = sb;  end
            3'd2: begin dx = sa;  dy = -sb; end
            3'd3: begin dx = -sa; dy = -sb; end
            3'd4: begin dx = sb;  dy = sa;  end
            3'd5: begin dx = -sb; dy = sa;  end
            3'd6: begin dx = sb;  dy = -sa; end
            default: begin dx = -sb; dy = -sa; end
        endcase
    end

    assign bxs = scx + dx;
    assign bys = scy + dy;
    assign bump_in = !bxs[CW-1] && !bys[CW-1]
                     && ($unsigned(bxs) < CW'(w_lim)) && ($unsigned(bys) < CW'(h_lim));
    assign bump_addr = {bys[YB-1:0], bxs[XB-1:0], ridx_reg};
    assign step_last = (k_reg == 3'd7) && !(a_reg < b_reg);
    assign rad_last  = (4'(ridx_reg) + 4'd1) >= 4'(n_used);

    assign p_r  = paddr_reg[RB-1:0];
    assign p_x  = paddr_reg[RB +: XB];
    assign p_y  = paddr_reg[RB+XB +: YB];
    assign p_in = (11'(p_x) < w_lim) && (11'(p_y) < h_lim) && (4'(p_r) < 4'(n_used));

    // Memory port control and shared multiplier operands.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = waddr_reg;
        mem_raddr = bump_addr;
        mem_wdata = rdata_reg + 16'd1;
        mreq.op_a = MW'(inv_reg);
        mreq.op_b = MW'(ex_reg);
        unique case (state_reg)
            S_SCAN:
            begin
                mem_we    = 1'b1;
                mem_re    = 1'b1;
                mem_waddr = cnt_reg;
                mem_raddr = cnt_reg;
                mem_wdata = 16'd0;
            end
            S_RD:  mem_re = bump_in;
            S_WR:  mem_we = 1'b1;
            S_VSY: mreq.op_b = MW'(ey_reg);
            S_VRM: mreq.op_b = MW'(rtab_reg[{2'(ridx_reg), 3'b000} +: 8]);
            S_T0:  mreq.op_b = MW'(rtab_reg[{2'(bi_reg), 3'b000} +: 8]);
            S_T1:
            begin
                mreq.op_a = MW'(hcbm_pkg::E_SLOPE);
                mreq.op_b = MW'(prod[8 +: RSB]);
            end
            S_T2:
            begin
                mreq.op_a = MW'(hcbm_pkg::RECIP_K);
                mreq.op_b = MW'(prod[18:0]) + MW'(hcbm_pkg::E_OFFSET);
            end
            S_T3:
            begin
                mreq.op_a = MW'(frac_reg);
                mreq.op_b = MW'(prod[hcbm_pkg::RECIP_SH +: 12]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = (in_data.command == hcbm_pkg::CMD_FINISH) ? S_SCAN : S_VSX;
            S_SCAN:  if (&cnt_reg) state_next = cmp_reg ? S_DRAIN : S_IDLE;
            S_DRAIN: state_next = S_T0;
            S_VSX:   state_next = S_VSY;
            S_VSY:   state_next = S_VCY;
            S_VCY:   state_next = (n_used == 3'd0) ? S_IDLE : S_VRM;
            S_VRM:   state_next = S_VRI;
            S_VRI:   state_next = S_RD;
            S_RD,
            S_WR:
            begin
                if (state_reg == S_RD && bump_in)
                    state_next = S_WR;
                else if (step_last)
                    state_next = rad_last ? S_IDLE : S_VRM;
                else
                    state_next = S_RD;
            end
            S_T0:    state_next = S_T1;
            S_T1:    state_next = S_T2;
            S_T2:    state_next = S_T3;
            S_T3:    state_next = S_T4;
            S_T4:    state_next = S_OUT;
            S_OUT:   if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SCAN;
            cnt_reg       <= '0;
            cmp_reg       <= 1'b0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_w_reg     <= 8'd128;
            acc_h_reg     <= 8'd128;
            inv_reg       <= 9'd256;
            rtab_reg      <= 32'd0;
            nrad_reg      <= 3'd1;
            frac_reg      <= 9'd128;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    hcbm_pkg::REG_ACCUM_WIDTH:  acc_w_reg <= cfg_data[7:0];
                    hcbm_pkg::REG_ACCUM_HEIGHT: acc_h_reg <= cfg_data[7:0];
                    hcbm_pkg::REG_INV_SCALE:    inv_reg   <= cfg_data[8:0];
                    hcbm_pkg::REG_RADIUS_TABLE: rtab_reg  <= cfg_data;
                    hcbm_pkg::REG_NUM_RADII:    nrad_reg  <= cfg_data[2:0];
                    hcbm_pkg::REG_VOTE_FRAC:    frac_reg  <= cfg_data[8:0];
                    default: ;
                endcase
            end
            if (state_reg == S_IDLE && in_valid && in_data.command == hcbm_pkg::CMD_FINISH)
            begin
                cnt_reg <= '0;
                cmp_reg <= 1'b1;
            end
            else if (state_reg == S_SCAN)
                cnt_reg <= cnt_reg + 1'b1;
            pv_reg <= (state_reg == S_SCAN) && cmp_reg;
            if (state_reg == S_OUT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        paddr_reg <= cnt_reg;
        if (state_reg == S_IDLE && in_valid)
        begin
            ex_reg   <= COORD_BITS'(in_data.edge_x);
            ey_reg   <= COORD_BITS'(in_data.edge_y);
            best_reg <= '0;
            bx_reg   <= '0;
            by_reg   <= '0;
            bi_reg   <= '0;
            ridx_reg <= '0;
        end
        if (pv_reg && p_in && rdata_reg > best_reg)
        begin
            best_reg <= rdata_reg;
            bx_reg   <= p_x;
            by_reg   <= p_y;
            bi_reg   <= p_r;
        end
        unique case (state_reg)
            S_VSY: cx_reg <= prod[8 +: CXW];
            S_VCY: cy_reg <= prod[8 +: CXW];
            S_VRI:
            begin
                a_reg <= '0;
                b_reg <= prod[8 +: RSB];
                d_reg <= DB'(1) - $signed(DB'(prod[8 +: RSB]));
                k_reg <= '0;
            end
            S_RD,
            S_WR:
            begin
                if (state_reg == S_RD && bump_in)
                    waddr_reg <= bump_addr;
                else if (k_reg != 3'd7)
                    k_reg <= k_reg + 3'd1;
                else if (a_reg < b_reg)
                begin
                    k_reg <= '0;
                    a_reg <= a_reg + 1'b1;
                    if (d_reg < 0)
                        d_reg <= d_reg + $signed(DB'({a_reg + 1'b1, 1'b1}));
                    else
                    begin
                        b_reg <= b_reg - 1'b1;
                        d_reg <= d_reg + DB'($signed({a_reg - b_reg + 2'd2, 1'b1}));
                    end
                end
                else
                    ridx_reg <= ridx_reg + 1'b1;
            end
            S_T4: thr_reg <= prod[8 +: 13];
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_reg.found        <= (best_reg != 16'd0) && (best_reg >= 16'(thr_reg));
                    out_reg.center_x     <= 7'(bx_reg);
                    out_reg.center_y     <= 7'(by_reg);
                    out_reg.radius_index <= 2'(bi_reg);
                    out_reg.votes        <= best_reg;
                end
            end
            default: ;
        endcase
    end

    `HCBM_AST_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `HCBM_AST_NXT(a_rmw_pairs, state_reg == S_RD && bump_in, state_reg == S_WR)
    `HCBM_AST_NXT(a_best_monotonic, state_reg == S_SCAN && pv_reg, best_reg >= $past(best_reg))
    `HCBM_AST_IMP(a_scan_quiet, state_reg == S_SCAN, !out_valid_reg || cmp_reg || !in_ready)

endmodule
